### hdl/sct_pkg.sv
package sct_pkg;

  // fixed field formats
  localparam int ANGLE_W         = 32;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int OUT_W           = 16;
  localparam int OUT_FRAC_BITS   = 14;

  // one-degree tables
  localparam int TABLE_ENTRIES   = 361;
  localparam int FULL_TURN       = 360;
  localparam int THREE_QUARTER   = 270;
  localparam int HALF_TURN       = 180;
  localparam int QUARTER_TURN    = 90;
  localparam int QUARTER_ENTRIES = QUARTER_TURN + 1;
  localparam int DEG_W           = $clog2(TABLE_ENTRIES);
  localparam int QIDX_W          = $clog2(QUARTER_ENTRIES);

  // angle reduction: whole degrees are offset by whole turns to stay positive,
  // then split into a high part (table) and a low part (added directly)
  localparam int WHOLE_W      = ANGLE_W - ANGLE_FRAC_BITS;
  localparam int OFFSET_TURNS = ((1 << (WHOLE_W - 1)) + FULL_TURN - 1) / FULL_TURN;
  localparam int WRAP_OFFSET  = OFFSET_TURNS * FULL_TURN;
  localparam int SHIFTED_W    = WHOLE_W + 1;
  localparam int LOW_W        = DEG_W;
  localparam int HIGH_W       = SHIFTED_W - LOW_W;
  localparam int HIGH_ENTRIES = 1 << HIGH_W;
  localparam int SUM_W        = DEG_W + 1;

  // interpolation accumulator
  localparam int ACC_W = OUT_W + ANGLE_FRAC_BITS + 2;

  // series constants for building the quarter-wave table
  localparam logic [63:0] PI_Q30       = 64'd3373259426;
  localparam logic [63:0] Q30_ONE      = 64'd1 << 30;
  localparam int          TAYLOR_TERMS = 12;
  localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  typedef logic [OUT_W-2:0]        qval_t;
  typedef qval_t                   qrom_t [QUARTER_ENTRIES];
  typedef logic [DEG_W-1:0]        deg_t;
  typedef deg_t                    modrom_t [HIGH_ENTRIES];
  typedef logic signed [OUT_W-1:0] sample_t;

  // sin(k deg) for k in 0..90, Q2.30 series rounded half up to the output format
  function automatic qval_t quarter_sine(int unsigned k);
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic [63:0]        q;
    if (k == 0) begin
      q = 64'd0;
    end else if (k >= QUARTER_TURN) begin
      q = Q30_ONE;
    end else begin
      x   = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
      t   = x;
      sum = signed'(x);
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / TAYLOR_DIV[n-1];
        if ((n & 1) != 0) begin
          sum = sum - signed'(t);
        end else begin
          sum = sum + signed'(t);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      if (sum > signed'(Q30_ONE)) begin
        sum = signed'(Q30_ONE);
      end
      q = unsigned'(sum);
    end
    q = (q + (64'd1 << (29 - OUT_FRAC_BITS))) >> (30 - OUT_FRAC_BITS);
    return q[OUT_W-2:0];
  endfunction

  function automatic qrom_t build_qrom();
    qrom_t r;
    for (int k = 0; k < QUARTER_ENTRIES; k++) begin
      r[k] = quarter_sine(k);
    end
    return r;
  endfunction

  // (high part * 2^LOW_W) mod 360
  function automatic modrom_t build_modrom();
    modrom_t r;
    for (int h = 0; h < HIGH_ENTRIES; h++) begin
      r[h] = DEG_W'((h * (1 << LOW_W)) % FULL_TURN);
    end
    return r;
  endfunction

  localparam qrom_t   QSIN      = build_qrom();
  localparam modrom_t MOD_HIGH  = build_modrom();

  // full-turn sine from the quarter-wave table, k in 0..360
  function automatic sample_t sine_at(deg_t k);
    deg_t    fk;
    logic    neg;
    sample_t mag;
    if (k <= DEG_W'(QUARTER_TURN)) begin
      fk  = k;
      neg = 1'b0;
    end else if (k <= DEG_W'(HALF_TURN)) begin
      fk  = DEG_W'(HALF_TURN) - k;
      neg = 1'b0;
    end else if (k <= DEG_W'(THREE_QUARTER)) begin
      fk  = k - DEG_W'(HALF_TURN);
      neg = 1'b1;
    end else begin
      fk  = DEG_W'(FULL_TURN) - k;
      neg = 1'b1;
    end
    mag = signed'({1'b0, QSIN[fk[QIDX_W-1:0]]});
    return neg ? -mag : mag;
  endfunction

endpackage

### hdl/sct_angle_if.sv
interface sct_angle_if import sct_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle_deg;

  modport source (output valid, output angle_deg, input ready);
  modport sink   (input valid, input angle_deg, output ready);
endinterface

### hdl/sct_result_if.sv
interface sct_result_if import sct_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] sine_value;
  logic signed [OUT_W-1:0] cosine_value;

  modport source (output valid, output sine_value, output cosine_value, input ready);
  modport sink   (input valid, input sine_value, input cosine_value, output ready);
endinterface

### hdl/sine_cosine_table_interpolator_top.sv
// Sine and cosine of an angle in degrees by one-degree table lookup and
// linear interpolation.
// in_i carries one signed angle per beat (16 fraction bits); out_o carries
// the matching sine and cosine in Q1.14, one beat per input beat, in order.
// Both channels use valid/ready; a beat moves when both are high.
// Pipeline: the angle is reduced mod 360 into the first register, the four
// neighboring table samples are read into the second, and the two
// interpolations (one 17x17 multiply each) fill the output register.
// Throughput is one beat per cycle while out_o.ready is high; each stage
// has its own valid bit, so an empty stage keeps taking beats while the
// output waits.
// When out_o.ready is low the output holds; stalls ripple back stage by
// stage and in_i.ready drops only once every stage is full.
// Reset clears all stage valid bits; the tables are constant logic and need
// no loading.
module sine_cosine_table_interpolator_top import sct_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  sct_angle_if.sink    in_i,
  sct_result_if.source out_o
);

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (ANGLE_FRAC_BITS - 1);

  // interpolate lo + frac*(hi-lo), rounded half up
  function automatic sample_t interp(sample_t lo, sample_t hi,
                                     logic [ANGLE_FRAC_BITS-1:0] frac);
    logic signed [OUT_W:0]     diff;
    logic signed [ACC_W-1:0]   prod;
    logic signed [ACC_W-1:0]   acc;
    diff = signed'({hi[OUT_W-1], hi}) - signed'({lo[OUT_W-1], lo});
    prod = diff * signed'({1'b0, frac});
    acc  = (ACC_W'(lo) <<< ANGLE_FRAC_BITS) + prod + ROUND_HALF;
    return acc[ANGLE_FRAC_BITS+OUT_W-1:ANGLE_FRAC_BITS];
  endfunction

  // stage enables
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic en1, en2, en3;

  assign en3        = !out_valid_q || out_o.ready;
  assign en2        = !s2_valid_q || en3;
  assign en1        = !s1_valid_q || en2;
  assign in_i.ready = en1;

  // angle reduction mod 360
  logic [WHOLE_W-1:0]         whole;
  logic [SHIFTED_W-1:0]       shifted;
  logic [SUM_W-1:0]           part_sum;
  deg_t                       deg_d;

  assign whole    = in_i.angle_deg[ANGLE_W-1:ANGLE_FRAC_BITS];
  assign shifted  = {whole[WHOLE_W-1], whole} + SHIFTED_W'(WRAP_OFFSET);
  assign part_sum = SUM_W'(MOD_HIGH[shifted[SHIFTED_W-1:LOW_W]])
                  + SUM_W'(shifted[LOW_W-1:0]);

  always_comb begin
    if (part_sum >= SUM_W'(2 * FULL_TURN)) begin
      deg_d = DEG_W'(part_sum - SUM_W'(2 * FULL_TURN));
    end else if (part_sum >= SUM_W'(FULL_TURN)) begin
      deg_d = DEG_W'(part_sum - SUM_W'(FULL_TURN));
    end else begin
      deg_d = DEG_W'(part_sum);
    end
  end

  deg_t                       s1_deg_q;
  logic [ANGLE_FRAC_BITS-1:0] s1_frac_q;

  // table indexes for the neighboring samples
  deg_t sin_k1, cos_k0_raw, cos_k1_raw, cos_k0, cos_k1;

  assign sin_k1     = s1_deg_q + DEG_W'(1);
  assign cos_k0_raw = s1_deg_q + DEG_W'(QUARTER_TURN);
  assign cos_k1_raw = s1_deg_q + DEG_W'(QUARTER_TURN + 1);
  assign cos_k0     = (cos_k0_raw >= DEG_W'(FULL_TURN)) ?
                      cos_k0_raw - DEG_W'(FULL_TURN) : cos_k0_raw;
  assign cos_k1     = (cos_k1_raw >= DEG_W'(FULL_TURN)) ?
                      cos_k1_raw - DEG_W'(FULL_TURN) : cos_k1_raw;

  logic [ANGLE_FRAC_BITS-1:0] s2_frac_q;
  sample_t                    sin_lo_q, sin_hi_q, cos_lo_q, cos_hi_q;
  sample_t                    sine_q, cosine_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_q <= in_i.valid;
      end
      if (en2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (en3) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (en1 && in_i.valid) begin
      s1_deg_q  <= deg_d;
      s1_frac_q <= in_i.angle_deg[ANGLE_FRAC_BITS-1:0];
    end
    if (en2 && s1_valid_q) begin
      s2_frac_q <= s1_frac_q;
      sin_lo_q  <= sine_at(s1_deg_q);
      sin_hi_q  <= sine_at(sin_k1);
      cos_lo_q  <= sine_at(cos_k0);
      cos_hi_q  <= sine_at(cos_k1);
    end
    if (en3 && s2_valid_q) begin
      sine_q   <= interp(sin_lo_q, sin_hi_q, s2_frac_q);
      cosine_q <= interp(cos_lo_q, cos_hi_q, s2_frac_q);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sine_value   = sine_q;
  assign out_o.cosine_value = cosine_q;

endmodule

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sct_pkg::*;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          PHASE_BEATS  = 650;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          MAX_PRINTS   = 40;
  localparam int          DEG_ONE      = 1 << ANGLE_FRAC_BITS;
  localparam longint      TURN_FIX     = longint'(FULL_TURN) * DEG_ONE;
  localparam longint      UNIT_OUT     = longint'(1) << OUT_FRAC_BITS;
  localparam logic [63:0] PI_FIX30     = 64'd3373259426;
  localparam int          SERIES_TERMS = 12;

  typedef logic signed [ANGLE_W-1:0] angle_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] sin_v;
    logic signed [OUT_W-1:0] cos_v;
  } trig_t;

  typedef struct packed {
    angle_t                  angle;
    logic                    known;
    logic signed [OUT_W-1:0] sin_v;
    logic signed [OUT_W-1:0] cos_v;
  } dir_row_t;

  localparam int N_DIRECTED = 21;

  // cardinal angles carry their result; the rest go through the predictor
  dir_row_t dir_rows [N_DIRECTED] = '{
    '{32'sd0,                 1'b1, 16'sd0,      16'sd16384},
    '{90 * DEG_ONE,           1'b1, 16'sd16384,  16'sd0},
    '{180 * DEG_ONE,          1'b1, 16'sd0,      -16'sd16384},
    '{270 * DEG_ONE,          1'b1, -16'sd16384, 16'sd0},
    '{360 * DEG_ONE,          1'b1, 16'sd0,      16'sd16384},
    '{-90 * DEG_ONE,          1'b1, -16'sd16384, 16'sd0},
    '{-360 * DEG_ONE,         1'b1, 16'sd0,      16'sd16384},
    '{32'sh7FFFFFFF,          1'b0, 16'sd0,      16'sd0},
    '{32'sh80000000,          1'b0, 16'sd0,      16'sd0},
    '{-32'sd1,                1'b0, 16'sd0,      16'sd0},
    '{32'sd1,                 1'b0, 16'sd0,      16'sd0},
    '{359 * DEG_ONE + 65535,  1'b0, 16'sd0,      16'sd0},
    '{359 * DEG_ONE,          1'b0, 16'sd0,      16'sd0},
    '{45 * DEG_ONE,           1'b0, 16'sd0,      16'sd0},
    '{30 * DEG_ONE + 32768,   1'b0, 16'sd0,      16'sd0},
    '{89 * DEG_ONE + 65535,   1'b0, 16'sd0,      16'sd0},
    '{-180 * DEG_ONE - 1,     1'b0, 16'sd0,      16'sd0},
    '{32'sh7FFF0000,          1'b0, 16'sd0,      16'sd0},
    '{32'sh5555AAAA,          1'b0, 16'sd0,      16'sd0},
    '{32'shAAAA5555,          1'b0, 16'sd0,      16'sd0},
    '{720 * DEG_ONE + 1,      1'b0, 16'sd0,      16'sd0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sct_angle_if  angle_bus ();
  sct_result_if trig_bus ();

  sine_cosine_table_interpolator_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (angle_bus),
    .out_o  (trig_bus)
  );

  longint      sine_tab   [TABLE_ENTRIES];
  longint      cosine_tab [TABLE_ENTRIES];
  trig_t       pending_trig [$];
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  int unsigned mismatches;
  int unsigned cycle_count;

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // sin(k deg) for k in 0..90 from the Q2.30 series, rounded to the output format
  function automatic longint quarter_mag(int k);
    logic [63:0] x;
    logic [63:0] t;
    longint      acc;
    if (k <= 0) begin
      acc = 0;
    end else if (k >= QUARTER_TURN) begin
      acc = longint'(1) << 30;
    end else begin
      x   = (64'(k) * PI_FIX30 + 64'd90) / 64'd180;
      t   = x;
      acc = longint'(x);
      for (int n = 1; n <= SERIES_TERMS; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(t);
        end else begin
          acc = acc + longint'(t);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      if (acc > (longint'(1) << 30)) begin
        acc = longint'(1) << 30;
      end
    end
    return (acc + (longint'(1) << (29 - OUT_FRAC_BITS))) >>> (30 - OUT_FRAC_BITS);
  endfunction

  // quadrant folding over the whole turn
  function automatic longint full_turn_sine(int k);
    if (k <= 90) begin
      return quarter_mag(k);
    end else if (k <= 180) begin
      return quarter_mag(180 - k);
    end else if (k <= 270) begin
      return -quarter_mag(k - 180);
    end
    return -quarter_mag(360 - k);
  endfunction

  function automatic void fill_tables();
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      sine_tab[k]   = full_turn_sine(k);
      cosine_tab[k] = full_turn_sine((k + 90) % 360);
    end
  endfunction

  // lo + frac*(hi-lo), rounded half up to the output format
  function automatic logic signed [OUT_W-1:0] lerp(longint lo, longint hi, longint frac);
    longint v;
    v = (lo + UNIT_OUT) * DEG_ONE + (hi - lo) * frac
        + (longint'(1) << (ANGLE_FRAC_BITS - 1));
    if (v < 0) begin
      v = 0;
    end
    return OUT_W'((v >>> ANGLE_FRAC_BITS) - UNIT_OUT);
  endfunction

  // reduce mod 360, split whole degree and fraction, interpolate both tables
  function automatic trig_t predict_trig(angle_t a);
    longint r;
    int     idx;
    longint frac;
    trig_t  res;
    r = longint'(a) % TURN_FIX;
    if (r < 0) begin
      r = r + TURN_FIX;
    end
    idx = int'(r >>> ANGLE_FRAC_BITS);
    if (idx > TABLE_ENTRIES - 2) begin
      idx = TABLE_ENTRIES - 2;
    end
    frac = r & (DEG_ONE - 1);
    res.sin_v = lerp(sine_tab[idx], sine_tab[idx + 1], frac);
    res.cos_v = lerp(cosine_tab[idx], cosine_tab[idx + 1], frac);
    return res;
  endfunction

  // mix of full-range words, angles near a few turns and exact or edge fractions
  function automatic angle_t pick_angle();
    int unsigned kind;
    int          whole;
    logic [15:0] frac;
    kind = $urandom_range(9);
    frac = 16'($urandom());
    if (kind <= 3) begin
      return angle_t'($urandom());
    end else if (kind <= 6) begin
      whole = int'($urandom_range(1440)) - 720;
    end else begin
      whole = int'($urandom_range(65535)) - 32768;
      case ($urandom_range(4))
        0: frac = 16'h0000;
        1: frac = 16'h0001;
        2: frac = 16'hFFFF;
        3: frac = 16'h8000;
        default: ;
      endcase
    end
    return {whole[15:0], frac};
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTS) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
    mismatches++;
  endtask

  // offer one angle beat, idling first at random, and queue its result once taken
  task automatic send_angle(input angle_t a, input bit typed, input trig_t typed_res);
    bit taken;
    while ($urandom_range(99) < send_gap_pct) begin
      angle_bus.valid     <= 1'b0;
      angle_bus.angle_deg <= angle_t'($urandom());
      @(posedge clk_i);
    end
    angle_bus.valid     <= 1'b1;
    angle_bus.angle_deg <= a;
    do begin
      @(negedge clk_i);
      taken = angle_bus.ready;
      @(posedge clk_i);
    end while (!taken);
    pending_trig.push_back(typed ? typed_res : predict_trig(a));
  endtask

  // stimulus
  initial begin
    trig_t typed_res;
    fill_tables();
    send_gap_pct        = 22;
    recv_stall_pct      = 74;
    angle_bus.valid     <= 1'b0;
    angle_bus.angle_deg <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed beats, then random beats against a slow receiver
    foreach (dir_rows[i]) begin
      typed_res.sin_v = dir_rows[i].sin_v;
      typed_res.cos_v = dir_rows[i].cos_v;
      send_angle(dir_rows[i].angle, dir_rows[i].known, typed_res);
    end
    for (int n = 0; n < PHASE_BEATS; n++) begin
      send_angle(pick_angle(), 1'b0, typed_res);
    end

    // receiver fast, sender sparse
    send_gap_pct   = 74;
    recv_stall_pct = 22;
    for (int n = 0; n < PHASE_BEATS; n++) begin
      send_angle(pick_angle(), 1'b0, typed_res);
    end

    // back to back, with one long receiver hold-off to fill the pipeline
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    for (int n = 0; n < PHASE_BEATS; n++) begin
      send_angle(pick_angle(), 1'b0, typed_res);
    end
    angle_bus.valid <= 1'b0;

    // drain and let the pipeline settle
    while (pending_trig.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // result ready, random stalls plus the long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left      = 0;
    trig_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        trig_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        trig_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare each result beat with the oldest expectation
  initial begin
    trig_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && trig_bus.valid && trig_bus.ready) begin
        if (pending_trig.size() == 0) begin
          report_mismatch($sformatf("unexpected beat sin %0d cos %0d",
                                    trig_bus.sine_value, trig_bus.cosine_value));
        end else begin
          want = pending_trig.pop_front();
          if (trig_bus.sine_value !== want.sin_v) begin
            report_mismatch($sformatf("sine %0d, expected %0d",
                                      trig_bus.sine_value, want.sin_v));
          end
          if (trig_bus.cosine_value !== want.cos_v) begin
            report_mismatch($sformatf("cosine %0d, expected %0d",
                                      trig_bus.cosine_value, want.cos_v));
          end
        end
      end
    end
  end

  // timeout
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench NOT OK");
    $finish;
  end

endmodule

### sine_cosine_table_interpolator_top.f
hdl/sct_pkg.sv
hdl/sct_angle_if.sv
hdl/sct_result_if.sv
hdl/sine_cosine_table_interpolator_top.sv
sim/testbench.sv
